// ===== rtl/flci_pkg.sv =====
// flci_pkg: shared types and constants of the flash command interface
// no dependencies

package flci_pkg;

   localparam int STORE_BYTES_DEF  = 131072;
   localparam int BANK_BYTES       = 65536;
   localparam int SECTOR_BYTES_DEF = 4096;
   localparam int OP_ADDR_W        = 17;

   localparam logic [15:0] ADDR_FIRST  = 16'h5555;
   localparam logic [15:0] ADDR_SECOND = 16'h2AAA;
   localparam logic [7:0]  BYTE_FIRST  = 8'hAA;
   localparam logic [7:0]  BYTE_SECOND = 8'h55;
   localparam logic [7:0]  CMD_ID         = 8'h90;
   localparam logic [7:0]  CMD_RESET      = 8'hF0;
   localparam logic [7:0]  CMD_ERASE      = 8'h80;
   localparam logic [7:0]  CMD_CHIP_ERASE = 8'h10;
   localparam logic [7:0]  CMD_PROGRAM    = 8'hA0;
   localparam logic [7:0]  CMD_BANK       = 8'hB0;
   localparam logic [7:0]  CMD_SECTOR     = 8'h30;
   localparam logic [7:0]  ID_MFR_RESET   = 8'h62;
   localparam logic [7:0]  ID_DEV_RESET   = 8'h13;
   localparam logic [7:0]  ERASED_BYTE    = 8'hFF;

   localparam logic [2:0] MODE_READ    = 3'd0;
   localparam logic [2:0] MODE_ID      = 3'd1;
   localparam logic [2:0] MODE_ERASE   = 3'd2;
   localparam logic [2:0] MODE_PROGRAM = 3'd3;
   localparam logic [2:0] MODE_BANK    = 3'd4;

   localparam logic CSR_ID_MFR = 1'b0;
   localparam logic CSR_ID_DEV = 1'b1;

   typedef enum logic [1:0] {
      OP_DIRECT = 2'd0,
      OP_READ   = 2'd1,
      OP_WRITE  = 2'd2,
      OP_FILL   = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type           kind;
      logic [OP_ADDR_W-1:0]  addr;
      logic [7:0]            data;
      logic                  chip;
      logic [2:0]            cmode;
   } op_type;

endpackage

// ===== rtl/flci_front.sv =====
// flci_front: accepts bus accesses, runs the unlock and mode logic
// depends on flci_pkg

module flci_front import flci_pkg::*; #(
   parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [15:0] req_offset,
   input  logic [7:0]  req_write_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        q_full,
   output logic        q_push,
   output op_type      q_op
);

   logic [7:0] first_ff, first_in, cmd_ff, cmd_in, second_ff, second_in;
   logic [1:0] idx_ff, idx_in;
   logic [2:0] mode_ff, mode_in;
   logic       bank_ff, bank_in;
   logic [7:0] mfr_ff, dev_ff;
   logic       act;
   logic [15:0] sec_base;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign sec_base  = req_offset & ~16'(SECTOR_BYTES - 1);

   always_comb begin
      first_in  = first_ff;
      cmd_in    = cmd_ff;
      second_in = second_ff;
      idx_in    = idx_ff;
      mode_in   = mode_ff;
      bank_in   = bank_ff;
      act       = 1'b0;
      q_op.kind  = OP_DIRECT;
      q_op.addr  = {bank_ff, req_offset};
      q_op.data  = 8'h00;
      q_op.chip  = 1'b0;
      if (!req_mode) begin
         if (mode_ff == MODE_ID && req_offset == 16'd0) begin
            q_op.data = mfr_ff;
         end else if (mode_ff == MODE_ID && req_offset == 16'd1) begin
            q_op.data = dev_ff;
         end else begin
            q_op.kind = OP_READ;
         end
      end else if (req_offset == ADDR_FIRST) begin
         if (idx_ff == 2'd0) first_in = req_write_data;
         else if (idx_ff == 2'd1) cmd_in = req_write_data;
         else second_in = req_write_data;
         act = 1'b1;
         if (second_in == BYTE_SECOND && idx_ff == 2'd1) begin
            first_in  = 8'h00;
            cmd_in    = 8'h00;
            second_in = 8'h00;
            idx_in    = 2'd0;
            act       = 1'b1;
            case (req_write_data)
               CMD_ID:      begin mode_in = MODE_ID;      act = 1'b0; end
               CMD_RESET:   begin mode_in = MODE_READ;    act = 1'b0; end
               CMD_ERASE:   begin mode_in = MODE_ERASE;   act = 1'b0; end
               CMD_PROGRAM: begin mode_in = MODE_PROGRAM; act = 1'b0; end
               CMD_BANK:    begin mode_in = MODE_BANK;    act = 1'b0; end
               CMD_CHIP_ERASE: begin
                  mode_in   = MODE_READ;
                  act       = 1'b0;
                  q_op.kind = OP_FILL;
                  q_op.chip = 1'b1;
               end
               default: act = 1'b1;
            endcase
         end
         if (act && first_in == BYTE_FIRST) begin
            act = 1'b0;
            if (idx_ff != 2'd2) idx_in = idx_ff + 2'd1;
         end
      end else if (first_ff == BYTE_FIRST && req_offset == ADDR_SECOND) begin
         second_in = req_write_data;
      end else begin
         act = 1'b1;
      end
      if (act) begin
         if (mode_ff == MODE_PROGRAM) begin
            q_op.kind = OP_WRITE;
            q_op.data = req_write_data;
         end else if (mode_ff == MODE_ERASE) begin
            if (first_in == BYTE_FIRST && second_in == BYTE_SECOND &&
                req_write_data == CMD_SECTOR) begin
               q_op.kind = OP_FILL;
               q_op.addr = {bank_ff, sec_base};
            end
         end else if (mode_ff == MODE_BANK) begin
            bank_in = req_write_data[0];
         end
      end
      q_op.cmode = req_mode ? mode_in : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= 8'h00;
         cmd_ff    <= 8'h00;
         second_ff <= 8'h00;
         idx_ff    <= 2'd0;
         mode_ff   <= MODE_READ;
         bank_ff   <= 1'b0;
         mfr_ff    <= ID_MFR_RESET;
         dev_ff    <= ID_DEV_RESET;
      end else begin
         if (q_push && req_mode) begin
            first_ff  <= first_in;
            cmd_ff    <= cmd_in;
            second_ff <= second_in;
            idx_ff    <= idx_in;
            mode_ff   <= mode_in;
            bank_ff   <= bank_in;
         end
         if (csr_write && csr_index == CSR_ID_MFR) mfr_ff <= csr_wdata;
         if (csr_write && csr_index == CSR_ID_DEV) dev_ff <= csr_wdata;
      end
   end

endmodule

// ===== rtl/flci_queue.sv =====
// flci_queue: two-entry operation queue between front and back
// depends on flci_pkg

module flci_queue import flci_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   empty,
   output op_type pop_op
);

   op_type     mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full   = cnt_ff == 2'd2;
   assign empty  = cnt_ff == 2'd0;
   assign pop_op = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== rtl/flci_back.sv =====
// flci_back: byte store, erase sweeps and the result register
// depends on flci_pkg

module flci_back import flci_pkg::*; #(
   parameter int STORE_BYTES  = STORE_BYTES_DEF,
   parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  op_type     q_op,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic [2:0] rsp_command_mode
);

   localparam int AW = $clog2(STORE_BYTES);
   localparam int SW = $clog2(SECTOR_BYTES);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_FILL  = 4'b1000
   } state_type;

   state_type  state_ff;
   logic [AW-1:0] addr_ff;
   logic       chip_ff;
   logic       valid_ff;
   logic [7:0] data_ff;
   logic [2:0] cmode_ff;
   logic [7:0] mem [STORE_BYTES];
   logic [7:0] mem_q_ff;
   logic       we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0] wdata;
   logic       fill_last;
   logic       rsp_set;

   assign rsp_valid        = valid_ff;
   assign rsp_read_data    = data_ff;
   assign rsp_command_mode = cmode_ff;

   assign q_pop = state_ff == ST_IDLE && !q_empty && (!valid_ff || rsp_ready);
   assign raddr = q_op.addr[AW-1:0];
   assign fill_last = chip_ff ? (addr_ff == AW'(STORE_BYTES - 1))
                              : (addr_ff[SW-1:0] == {SW{1'b1}});
   assign rsp_set = (q_pop && (q_op.kind == OP_DIRECT || q_op.kind == OP_WRITE)) ||
                    state_ff == ST_READ || (state_ff == ST_FILL && fill_last);

   always_comb begin
      we    = 1'b0;
      waddr = addr_ff;
      wdata = ERASED_BYTE;
      if (state_ff == ST_CLEAR || state_ff == ST_FILL) begin
         we = 1'b1;
      end else if (q_pop && q_op.kind == OP_WRITE) begin
         we    = 1'b1;
         waddr = q_op.addr[AW-1:0];
         wdata = q_op.data;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      mem_q_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         chip_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         if (rsp_set) valid_ff <= 1'b1;
         else if (valid_ff && rsp_ready) valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (fill_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (q_pop) begin
                  cmode_ff <= q_op.cmode;
                  case (q_op.kind)
                     OP_DIRECT: begin
                        data_ff  <= q_op.data;
                     end
                     OP_WRITE: begin
                        data_ff  <= 8'h00;
                     end
                     OP_READ: state_ff <= ST_READ;
                     OP_FILL: begin
                        chip_ff  <= q_op.chip;
                        addr_ff  <= q_op.chip ? '0 : q_op.addr[AW-1:0];
                        state_ff <= ST_FILL;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_READ: begin
               data_ff  <= mem_q_ff;
               state_ff <= ST_IDLE;
            end
            ST_FILL: begin
               addr_ff <= addr_ff + 1'b1;
               if (fill_last) begin
                  data_ff  <= 8'h00;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_read_reg_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !valid_ff)
      else $error("result register busy during read");
   a_fill_reg_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL |-> !valid_ff)
      else $error("result register busy during erase");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !q_pop)
      else $error("operation taken while busy");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |=> !valid_ff)
      else $error("result during clearing pass");

endmodule

// ===== rtl/flash_command_interface.sv =====
// flash_command_interface: top level of the flash unlock command interface
// depends on flci_pkg, flci_front, flci_queue, flci_back
//
// channel   ports                               direction
// req       req_valid/ready, mode, offset, data  in
// rsp       rsp_valid/ready, read_data, mode     out
// csr       csr_write, csr_index, csr_wdata      in
//
// reads pass through the queue, the registered store read data and the result
// register; writes set the result register when taken from the queue. sector erase
// sweeps SECTOR_BYTES bytes and chip erase STORE_BYTES bytes, one byte per cycle.
// after reset a clearing pass over all STORE_BYTES bytes runs before results flow.
// the two-entry queue lets accesses be accepted while the store is busy.

module flash_command_interface import flci_pkg::*; #(
   parameter int STORE_BYTES  = STORE_BYTES_DEF,
   parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [15:0] req_offset,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic [2:0]  rsp_command_mode,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic   q_push, q_full, q_pop, q_empty;
   op_type push_op, pop_op;

   flci_front #(.SECTOR_BYTES(SECTOR_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_offset,
      .req_write_data, .csr_write, .csr_index, .csr_wdata,
      .q_full, .q_push, .q_op(push_op)
   );

   flci_queue u_queue (
      .clock, .reset, .push(q_push), .push_op, .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_op
   );

   flci_back #(.STORE_BYTES(STORE_BYTES), .SECTOR_BYTES(SECTOR_BYTES)) u_back (
      .clock, .reset, .q_empty, .q_op(pop_op), .q_pop,
      .rsp_valid, .rsp_ready, .rsp_read_data, .rsp_command_mode
   );

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for flash_command_interface, unlock sequences and store ops
// depends on flci_pkg and the flash_command_interface rtl

module tb_top;
   import flci_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        wr;
      logic [15:0] off;
      logic [7:0]  data;
   } access_type;

   typedef struct {
      logic [7:0] rd;
      logic [2:0] cmode;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [15:0] req_offset = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [2:0]  rsp_command_mode;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = '0;

   flash_command_interface DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [7:0] flash_mem [STORE_BYTES_DEF];
   logic [7:0] id_mfr, id_dev, ul_first, ul_cmd, ul_second;
   logic [1:0] ul_index;
   logic [2:0] cur_mode;
   logic       bank;

   access_type pending_q[$];
   result_type expected_q[$];
   int      send_idle_pct = 0, recv_idle_pct = 0;
   bit      hold_rsp = 0;
   bit      req_taken = 0;
   int      errors = 0, idle_cycles = 0, fills = 0;

   function automatic logic [16:0] flash_addr(logic [16:0] off);
      return 17'((32'(bank) * BANK_BYTES + off) % STORE_BYTES_DEF);
   endfunction

   function automatic void flash_write(logic [15:0] off, logic [7:0] v);
      logic [1:0] idx;
      int base;
      if (off == ADDR_FIRST) begin
         idx = ul_index;
         if (idx == 0) ul_first = v;
         else if (idx == 1) ul_cmd = v;
         else ul_second = v;
         if (ul_second == BYTE_SECOND && idx == 1) begin
            ul_first = 0; ul_cmd = 0; ul_second = 0; ul_index = 0;
            case (v)
               CMD_ID: begin cur_mode = MODE_ID; return; end
               CMD_RESET: begin cur_mode = MODE_READ; return; end
               CMD_ERASE: begin cur_mode = MODE_ERASE; return; end
               CMD_CHIP_ERASE: begin
                  foreach (flash_mem[i]) flash_mem[i] = ERASED_BYTE;
                  cur_mode = MODE_READ;
                  return;
               end
               CMD_PROGRAM: begin cur_mode = MODE_PROGRAM; return; end
               CMD_BANK: begin cur_mode = MODE_BANK; return; end
               default: ;
            endcase
         end
         if (ul_first == BYTE_FIRST) begin
            if (ul_index < 2) ul_index++;
            return;
         end
      end else if (ul_first == BYTE_FIRST && off == ADDR_SECOND) begin
         ul_second = v;
         return;
      end
      if (cur_mode == MODE_PROGRAM) flash_mem[flash_addr(off)] = v;
      else if (cur_mode == MODE_ERASE) begin
         if (ul_first == BYTE_FIRST && ul_second == BYTE_SECOND && v == CMD_SECTOR) begin
            base = off - off % SECTOR_BYTES_DEF;
            for (int i = 0; i < SECTOR_BYTES_DEF && base + i < BANK_BYTES; i++)
               flash_mem[flash_addr(17'(base + i))] = ERASED_BYTE;
         end
      end else if (cur_mode == MODE_BANK) bank = v[0];
   endfunction

   function automatic result_type predict_access(access_type a);
      result_type r;
      r.rd = 8'h00;
      if (a.wr) flash_write(a.off, a.data);
      else if (cur_mode == MODE_ID && a.off == 0) r.rd = id_mfr;
      else if (cur_mode == MODE_ID && a.off == 1) r.rd = id_dev;
      else r.rd = flash_mem[flash_addr(a.off)];
      r.cmode = cur_mode;
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
         end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            access_type a;
            a = pending_q.pop_front();
            req_valid <= 1'b1;
            req_mode <= a.wr;
            req_offset <= a.off;
            req_write_data <= a.data;
         end else req_valid <= 1'b0;
         req_taken = 1'b0;
         rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_q.push_back(predict_access('{req_mode, req_offset, req_write_data}));
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected transaction rd=%h mode=%0d", $time,
                        rsp_read_data, rsp_command_mode);
               errors++;
            end else begin
               result_type e;
               e = expected_q.pop_front();
               if (e.rd !== rsp_read_data) begin
                  $display("%0t: read_data expected %h actual %h", $time, e.rd, rsp_read_data);
                  errors++;
               end
               if (e.cmode !== rsp_command_mode) begin
                  $display("%0t: command_mode expected %0d actual %0d", $time, e.cmode,
                           rsp_command_mode);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 600000) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic add(logic wr, logic [15:0] off, logic [7:0] d);
      access_type a;
      a.wr = wr; a.off = off; a.data = d;
      pending_q.push_back(a);
   endtask

   task automatic add_command(logic [7:0] c);
      add(1, ADDR_FIRST, BYTE_FIRST);
      add(1, ADDR_SECOND, BYTE_SECOND);
      add(1, ADDR_FIRST, c);
   endtask

   task automatic drain();
      while (pending_q.size() > 0 || expected_q.size() > 0 || req_valid) @(posedge clock);
      repeat (300000) @(posedge clock);
   endtask

   task automatic set_id(logic idx, logic [7:0] v);
      @(negedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_ID_MFR) id_mfr = v; else id_dev = v;
   endtask

   function automatic logic [15:0] rand_off();
      case ($urandom_range(5))
         0: return ADDR_FIRST;
         1: return ADDR_SECOND;
         2: return 16'($urandom_range(3));
         3: return 16'hFFFF - 16'($urandom_range(3));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_items(int n);
      logic [7:0] cmds [6];
      cmds = '{CMD_ID, CMD_RESET, CMD_ERASE, CMD_PROGRAM, CMD_BANK, CMD_CHIP_ERASE};
      for (int k = 0; k < n; ) begin
         int pick;
         pick = $urandom_range(99);
         if (pick < 30) begin
            int c;
            c = $urandom_range(fills < 2 ? 5 : 4);
            if (c == 5) fills++;
            add_command(cmds[c]);
            k += 3;
         end else if (pick < 33) begin
            add(1, ADDR_FIRST, BYTE_FIRST); add(1, ADDR_SECOND, BYTE_SECOND);
            add(1, 16'($urandom), CMD_SECTOR);
            k += 3;
         end else if (pick < 40) begin
            add(1, ADDR_FIRST, 8'($urandom)); k++;
         end else if (pick < 65) begin
            add(1, rand_off(), 8'($urandom)); k++;
         end else begin
            add(0, rand_off(), 8'($urandom)); k++;
         end
      end
   endtask

   initial begin
      foreach (flash_mem[i]) flash_mem[i] = ERASED_BYTE;
      id_mfr = ID_MFR_RESET; id_dev = ID_DEV_RESET;
      ul_first = 0; ul_cmd = 0; ul_second = 0; ul_index = 0;
      cur_mode = MODE_READ; bank = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_id(CSR_ID_MFR, 8'h00);
      set_id(CSR_ID_DEV, 8'hFF);

      // directed
      add(0, 16'h0000, 8'h00);
      add(0, 16'hFFFF, 8'hFF);
      add_command(CMD_ID);
      add(0, 16'h0000, 8'h00); add(0, 16'h0001, 8'h00); add(0, 16'h0002, 8'h00);
      add_command(CMD_PROGRAM);
      add(1, 16'h0000, 8'h00); add(1, 16'hFFFF, 8'h5A);
      add_command(CMD_BANK);
      add(1, 16'h1234, 8'h01);
      add_command(CMD_PROGRAM);
      add(1, 16'hFFFF, 8'hA5);
      add(0, 16'hFFFF, 8'h00);
      add_command(CMD_ERASE);
      add(1, ADDR_FIRST, BYTE_FIRST); add(1, ADDR_SECOND, BYTE_SECOND);
      add(1, 16'hF123, CMD_SECTOR);
      drain();
      set_id(CSR_ID_MFR, 8'hFF);
      set_id(CSR_ID_DEV, 8'h00);
      add_command(CMD_RESET);
      add_command(CMD_CHIP_ERASE);
      add(0, 16'h0000, 8'h00);
      add(1, ADDR_FIRST, 8'h12); add(1, ADDR_FIRST, 8'h34);
      drain();

      send_idle_pct = 19; recv_idle_pct = 66;
      random_items(500);
      drain();
      set_id(CSR_ID_MFR, 8'($urandom));
      set_id(CSR_ID_DEV, 8'($urandom));
      send_idle_pct = 66; recv_idle_pct = 19;
      random_items(500);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      hold_rsp = 1;
      random_items(500);
      repeat (200) @(posedge clock);
      hold_rsp = 0;
      drain();
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/flci_pkg.sv
rtl/flci_front.sv
rtl/flci_queue.sv
rtl/flci_back.sv
rtl/flash_command_interface.sv
sim/tb_top.sv
